// File: design/abcm_pkg.sv
package abcm_pkg;

  localparam int RKW_DEFAULT = 60;
  localparam logic [7:0] RED_POLY = 8'h1b;
  localparam logic [3:0] NR_128 = 4'd10;
  localparam logic [3:0] NR_192 = 4'd12;
  localparam logic [3:0] NR_256 = 4'd14;
  localparam logic [3:0] NK_128 = 4'd4;
  localparam logic [3:0] NK_192 = 4'd6;
  localparam logic [3:0] NK_256 = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PRE,
    ST_ADD0,
    ST_ROUND,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    REG_KEY_SIZE,
    REG_MODE,
    REG_KEY0,
    REG_KEY1,
    REG_KEY2,
    REG_KEY3,
    REG_IV_HIGH,
    REG_IV_LOW
  } reg_e;

  typedef enum logic [1:0] {
    KS_128,
    KS_192,
    KS_256,
    KS_ALT
  } key_size_e;

  typedef enum logic [1:0] {
    CH_ECB,
    CH_CBC,
    CH_CFB,
    CH_CFB_ALT
  } chain_e;

  typedef struct packed {
    logic accept;
    logic exp_step;
    logic set_valid;
    logic pre;
    logic add0;
    logic round_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sched_valid;
    logic exp_done;
    logic last_round;
  } status_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

// File: design/aes_block_cipher_modes_core.sv
// A block is accepted in the idle state, loaded with its chaining input, given
// the initial round key and run one AES round per cycle in a shared round unit.
// A stale key schedule is first expanded into the round key memory: 44, 52 or 60
// words for 128, 192 or 256-bit keys, one word per cycle, written in rows of four.
// A new block is accepted only after the previous result is in the output register.
// Reset clears the configuration registers, the chaining value and the schedule flag.
module aes_block_cipher_modes_core #(
  parameter int ROUND_KEY_WORDS = abcm_pkg::RKW_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // block_low, block_high
  input  logic         s_axis_tuser,  // first_of_message
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // result_low, result_high
);

  abcm_pkg::cmd_t    cmd;
  abcm_pkg::status_t status;
  logic [127:0]      in_data, out_data;

  assign cfg_ready_o = 1'b1;
  assign in_data = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign m_axis_tdata = out_data;

  abcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  abcm_dp #(
    .ROUND_KEY_WORDS(ROUND_KEY_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data),
    .in_first_i (s_axis_tuser),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data)
  );

endmodule

// File: design/abcm_ram.sv
module abcm_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/abcm_ctrl.sv
module abcm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  abcm_pkg::status_t status_i,
  output abcm_pkg::cmd_t    cmd_o
);

  abcm_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abcm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      abcm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.sched_valid ? abcm_pkg::ST_PRE : abcm_pkg::ST_EXPAND;
        end
      end
      abcm_pkg::ST_EXPAND: begin
        cmd_o.exp_step = 1'b1;
        if (status_i.exp_done) begin
          cmd_o.set_valid = 1'b1;
          state_d = abcm_pkg::ST_PRE;
        end
      end
      abcm_pkg::ST_PRE: begin
        cmd_o.pre = 1'b1;
        state_d = abcm_pkg::ST_ADD0;
      end
      abcm_pkg::ST_ADD0: begin
        cmd_o.add0 = 1'b1;
        state_d = abcm_pkg::ST_ROUND;
      end
      abcm_pkg::ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (status_i.last_round) begin
          state_d = abcm_pkg::ST_FINISH;
        end
      end
      abcm_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = abcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = abcm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_finish_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == abcm_pkg::ST_FINISH |=> out_valid_q)
    else $error("result not presented after the final round");

  a_last_round_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abcm_pkg::ST_ROUND && status_i.last_round) |=> state_q == abcm_pkg::ST_FINISH)
    else $error("round sequence overran the last round");

  a_no_accept_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (state_q == abcm_pkg::ST_IDLE))
    else $error("beat accepted while a block is in flight");

  a_expand_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abcm_pkg::ST_EXPAND && !status_i.exp_done) |=> state_q == abcm_pkg::ST_EXPAND)
    else $error("key expansion left early");
`endif

endmodule

// File: design/abcm_dp.sv
module abcm_dp #(
  parameter int ROUND_KEY_WORDS = abcm_pkg::RKW_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  input  logic [127:0]      in_data_i,
  input  logic              in_first_i,
  input  abcm_pkg::cmd_t    cmd_i,
  output abcm_pkg::status_t status_o,
  output logic [127:0]      out_data_o
);

  localparam int Rows = (ROUND_KEY_WORDS + 3) / 4;
  localparam int AddrW = $clog2(Rows > 1 ? Rows : 2);

  function automatic logic [7:0] xt(input logic [7:0] v);
    xt = {v[6:0], 1'b0} ^ (v[7] ? abcm_pkg::RED_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {abcm_pkg::FWD_BOX[w[31:24]], abcm_pkg::FWD_BOX[w[23:16]],
                abcm_pkg::FWD_BOX[w[15:8]], abcm_pkg::FWD_BOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      a[k]  = c[31-8*k -: 8];
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
      m2[k] = x2[k];
      m3[k] = x2[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int q = 0; q < 4; q++) begin
      if (inv) begin
        r[31-8*q -: 8] = me[q] ^ mb[(q+1)%4] ^ md[(q+2)%4] ^ m9[(q+3)%4];
      end else begin
        r[31-8*q -: 8] = m2[q] ^ m3[(q+1)%4] ^ a[(q+2)%4] ^ a[(q+3)%4];
      end
    end
    mix_col = r;
  endfunction

  function automatic logic [127:0] do_round(input logic [127:0] s, input logic [127:0] rk,
                                            input logic inv, input logic last);
    logic [127:0] t;
    logic [127:0] m;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127-8*(4*c+r) -: 8] = abcm_pkg::INV_BOX[s[127-8*(4*((c+4-r)%4)+r) -: 8]];
        end else begin
          t[127-8*(4*c+r) -: 8] = abcm_pkg::FWD_BOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
        end
      end
    end
    if (inv) begin
      t = t ^ rk;
    end
    for (int c = 0; c < 4; c++) begin
      m[127-32*c -: 32] = last ? t[127-32*c -: 32] : mix_col(t[127-32*c -: 32], inv);
    end
    do_round = inv ? m : (m ^ rk);
  endfunction

  logic [1:0]   key_size_q;
  logic [2:0]   mode_q;
  logic [63:0]  key_q [4];
  logic [63:0]  iv_hi_q, iv_lo_q;
  logic         valid_q;
  logic [127:0] blk_q, cv_q, st_q, res_q, row_q;
  logic [31:0]  win_q [8];
  logic [5:0]   i_q;
  logic [2:0]   j_q;
  logic [7:0]   rc_q;
  logic [3:0]   cnt_q, rd_row_q;

  logic [3:0]   nr, nk, rd_k, rd_row;
  logic         dec, core_dec;
  abcm_pkg::chain_e chain;
  logic [31:0]  kw32, far_w, t_w, new_w, push_w;
  logic [63:0]  kw;
  logic [127:0] rdata, rk, cin;
  logic         we;
  logic [AddrW-1:0] waddr, raddr;

  always_comb begin
    case (abcm_pkg::key_size_e'(key_size_q))
      abcm_pkg::KS_128: begin
        nr = abcm_pkg::NR_128;
        nk = abcm_pkg::NK_128;
      end
      abcm_pkg::KS_192: begin
        nr = abcm_pkg::NR_192;
        nk = abcm_pkg::NK_192;
      end
      default: begin
        nr = abcm_pkg::NR_256;
        nk = abcm_pkg::NK_256;
      end
    endcase
    case (abcm_pkg::chain_e'(mode_q[2:1]))
      abcm_pkg::CH_ECB: chain = abcm_pkg::CH_ECB;
      abcm_pkg::CH_CBC: chain = abcm_pkg::CH_CBC;
      default:          chain = abcm_pkg::CH_CFB;
    endcase
  end

  assign dec      = mode_q[0];
  assign core_dec = dec && (chain != abcm_pkg::CH_CFB);

  // Key schedule, one word per cycle.
  always_comb begin
    kw   = key_q[i_q[2:1]];
    kw32 = i_q[0] ? kw[31:0] : kw[63:32];
    case (nk)
      abcm_pkg::NK_128: far_w = win_q[4];
      abcm_pkg::NK_192: far_w = win_q[2];
      default:          far_w = win_q[0];
    endcase
    t_w = win_q[7];
    if (j_q == 3'd0) begin
      t_w = sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rc_q, 24'h0};
    end else if (nk == abcm_pkg::NK_256 && j_q == 3'd4) begin
      t_w = sub_word(win_q[7]);
    end
    new_w  = ({2'b0, i_q} < {4'b0, nk}) ? kw32 : (far_w ^ t_w);
    push_w = (int'(i_q) < ROUND_KEY_WORDS) ? new_w : 32'h0;
  end

  assign status_o.exp_done   = (i_q == {nr, 2'b11});
  assign status_o.last_round = (cnt_q == nr);
  assign status_o.sched_valid = valid_q;

  assign we    = cmd_i.exp_step && (i_q[1:0] == 2'b11) && (int'(i_q[5:2]) < Rows);
  assign waddr = AddrW'(i_q[5:2]);

  always_comb begin
    rd_k = cmd_i.pre ? 4'd0 : (cmd_i.add0 ? 4'd1 : cnt_q + 4'd1);
    rd_row = core_dec ? (nr - rd_k) : rd_k;
  end
  assign raddr = AddrW'(rd_row);

  abcm_ram #(
    .WIDTH(128),
    .DEPTH(Rows)
  ) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i({row_q[127:32], new_w}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rk[127-32*c -: 32] = (4 * int'(rd_row_q) + c < ROUND_KEY_WORDS) ?
                           rdata[127-32*c -: 32] : 32'h0;
    end
    case (chain)
      abcm_pkg::CH_ECB: cin = blk_q;
      abcm_pkg::CH_CBC: cin = dec ? blk_q : (blk_q ^ cv_q);
      default:          cin = cv_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_size_q <= 2'd0;
      mode_q     <= 3'd0;
      key_q      <= '{default: 64'h0};
      iv_hi_q    <= 64'h0;
      iv_lo_q    <= 64'h0;
      valid_q    <= 1'b0;
      cv_q       <= 128'h0;
      i_q        <= 6'd0;
      j_q        <= 3'd0;
      rc_q       <= 8'h01;
      cnt_q      <= 4'd0;
    end else begin
      if (cfg_valid_i) begin
        case (abcm_pkg::reg_e'(cfg_index_i))
          abcm_pkg::REG_KEY_SIZE: begin
            key_size_q <= cfg_data_i[1:0];
            valid_q    <= 1'b0;
          end
          abcm_pkg::REG_MODE:    mode_q <= cfg_data_i[2:0];
          abcm_pkg::REG_KEY0,
          abcm_pkg::REG_KEY1,
          abcm_pkg::REG_KEY2,
          abcm_pkg::REG_KEY3: begin
            key_q[cfg_index_i[1:0] - 2'd2] <= cfg_data_i;
            valid_q <= 1'b0;
          end
          abcm_pkg::REG_IV_HIGH: iv_hi_q <= cfg_data_i;
          abcm_pkg::REG_IV_LOW:  iv_lo_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        i_q  <= 6'd0;
        j_q  <= 3'd0;
        rc_q <= 8'h01;
        if (in_first_i) begin
          cv_q <= {iv_hi_q, iv_lo_q};
        end
      end
      if (cmd_i.exp_step) begin
        i_q <= i_q + 6'd1;
        j_q <= ({1'b0, j_q} == nk - 4'd1) ? 3'd0 : j_q + 3'd1;
        if (j_q == 3'd0 && {2'b0, i_q} >= {4'b0, nk}) begin
          rc_q <= xt(rc_q);
        end
      end
      if (cmd_i.set_valid) begin
        valid_q <= 1'b1;
      end
      if (cmd_i.add0) begin
        cnt_q <= 4'd1;
      end
      if (cmd_i.round_en) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (cmd_i.finish) begin
        case (chain)
          abcm_pkg::CH_ECB: ;
          abcm_pkg::CH_CBC: cv_q <= dec ? blk_q : st_q;
          default:          cv_q <= dec ? blk_q : (st_q ^ blk_q);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_row_q <= rd_row;
    if (cmd_i.accept) begin
      blk_q <= in_data_i;
    end
    if (cmd_i.exp_step) begin
      for (int k = 0; k < 7; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[7] <= push_w;
      row_q[127-32*i_q[1:0] -: 32] <= new_w;
    end
    if (cmd_i.pre) begin
      st_q <= cin;
    end
    if (cmd_i.add0) begin
      st_q <= st_q ^ rk;
    end
    if (cmd_i.round_en) begin
      st_q <= do_round(st_q, rk, core_dec, cnt_q == nr);
    end
    if (cmd_i.finish) begin
      case (chain)
        abcm_pkg::CH_ECB: res_q <= st_q;
        abcm_pkg::CH_CBC: res_q <= dec ? (st_q ^ cv_q) : st_q;
        default:          res_q <= st_q ^ blk_q;
      endcase
    end
  end

  assign out_data_o = {res_q[63:0], res_q[127:64]};

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    bit [63:0] hi;
    bit [63:0] lo;
  } block_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // block_low, block_high
  logic         s_axis_tuser = 1'b0;  // first_of_message
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;  // result_low, result_high

  aes_block_cipher_modes_core uut (.*);

  always #10 clk_i = ~clk_i;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          rx_hold = 1'b0;
  int unsigned error_count = 0;
  int unsigned blocks_sent = 0;
  event        stall_ev;

  block_t      expected_blocks[$];

  bit [1:0]    key_size_m = '0;
  bit [2:0]    mode_m = '0;
  bit [63:0]   key_m[4] = '{default: '0};
  bit [127:0]  iv_m = '0;
  bit [127:0]  chain_m = '0;
  bit [31:0]   round_keys[60];

  function automatic bit [7:0] gf_dbl(bit [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? abcm_pkg::RED_POLY : 8'h00);
  endfunction

  function automatic bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
    bit [7:0] acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  function automatic bit [31:0] sub_word(bit [31:0] w);
    return {abcm_pkg::FWD_BOX[w[31:24]], abcm_pkg::FWD_BOX[w[23:16]],
            abcm_pkg::FWD_BOX[w[15:8]], abcm_pkg::FWD_BOX[w[7:0]]};
  endfunction

  function automatic int rounds_for_key();
    return key_size_m == abcm_pkg::KS_128 ? 10 : key_size_m == abcm_pkg::KS_192 ? 12 : 14;
  endfunction

  function automatic void expand_schedule();
    int nk = key_size_m == abcm_pkg::KS_128 ? 4 : key_size_m == abcm_pkg::KS_192 ? 6 : 8;
    int total = 4 * (rounds_for_key() + 1);
    bit [7:0] rc = 8'h01;
    bit [31:0] t;
    for (int i = 0; i < nk; i++)
      round_keys[i] = i[0] ? key_m[i >> 1][31:0] : key_m[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = round_keys[i - 1];
      if (i % nk == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_word(t);
      end
      round_keys[i] = round_keys[i - nk] ^ t;
    end
  endfunction

  function automatic bit [127:0] add_round_key(bit [127:0] s, int rnd);
    for (int c = 0; c < 4; c++) s[127 - 32 * c -: 32] ^= round_keys[4 * rnd + c];
    return s;
  endfunction

  function automatic bit [127:0] sub_all(bit [127:0] s, bit inv);
    for (int i = 0; i < 16; i++)
      s[127 - 8 * i -: 8] = inv ? abcm_pkg::INV_BOX[s[127 - 8 * i -: 8]] :
                                  abcm_pkg::FWD_BOX[s[127 - 8 * i -: 8]];
    return s;
  endfunction

  function automatic bit [127:0] shift_all(bit [127:0] s, bit inv);
    bit [127:0] t;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + r) & 3) + r;
        if (inv) t[127 - 8 * src -: 8] = s[127 - 8 * (4 * c + r) -: 8];
        else t[127 - 8 * (4 * c + r) -: 8] = s[127 - 8 * src -: 8];
      end
    return t;
  endfunction

  function automatic bit [127:0] mix_all(bit [127:0] s, bit inv);
    bit [7:0] fwd_m[4] = '{8'd2, 8'd3, 8'd1, 8'd1};
    bit [7:0] inv_m[4] = '{8'd14, 8'd11, 8'd13, 8'd9};
    bit [7:0] col[4];
    bit [7:0] acc;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[127 - 8 * (4 * c + k) -: 8];
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc ^= gf_mul(col[k], inv ? inv_m[(k + 4 - r) & 3] : fwd_m[(k + 4 - r) & 3]);
        s[127 - 8 * (4 * c + r) -: 8] = acc;
      end
    end
    return s;
  endfunction

  function automatic bit [127:0] aes_core(bit [127:0] s, bit dec);
    int nr = rounds_for_key();
    if (!dec) begin
      s = add_round_key(s, 0);
      for (int rnd = 1; rnd < nr; rnd++)
        s = add_round_key(mix_all(shift_all(sub_all(s, 0), 0), 0), rnd);
      s = add_round_key(shift_all(sub_all(s, 0), 0), nr);
    end else begin
      s = add_round_key(s, nr);
      for (int rnd = nr - 1; rnd >= 1; rnd--)
        s = mix_all(add_round_key(sub_all(shift_all(s, 1), 1), rnd), 1);
      s = add_round_key(sub_all(shift_all(s, 1), 1), 0);
    end
    return s;
  endfunction

  // The schedule is rebuilt for every block: a key write always invalidates it,
  // so this gives the same round keys as expanding only when stale.
  function automatic void predict_block(bit [63:0] hi, bit [63:0] lo, bit first);
    abcm_pkg::chain_e ch = abcm_pkg::chain_e'(mode_m[2:1]);
    bit dec = mode_m[0];
    bit [127:0] blk = {hi, lo};
    bit [127:0] s;
    block_t res;
    if (first) chain_m = iv_m;
    expand_schedule();
    case (ch)
      abcm_pkg::CH_ECB: begin
        s = aes_core(blk, dec);
      end
      abcm_pkg::CH_CBC: begin
        if (dec) begin
          s = aes_core(blk, 1) ^ chain_m;
          chain_m = blk;
        end else begin
          s = aes_core(blk ^ chain_m, 0);
          chain_m = s;
        end
      end
      default: begin
        s = aes_core(chain_m, 0) ^ blk;
        chain_m = dec ? blk : s;
      end
    endcase
    res.hi = s[127:64];
    res.lo = s[63:0];
    expected_blocks.push_back(res);
  endfunction

  task automatic cfg_write(abcm_pkg::reg_e idx, bit [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      abcm_pkg::REG_KEY_SIZE: key_size_m = val[1:0];
      abcm_pkg::REG_MODE:     mode_m = val[2:0];
      abcm_pkg::REG_KEY0:     key_m[0] = val;
      abcm_pkg::REG_KEY1:     key_m[1] = val;
      abcm_pkg::REG_KEY2:     key_m[2] = val;
      abcm_pkg::REG_KEY3:     key_m[3] = val;
      abcm_pkg::REG_IV_HIGH:  iv_m[127:64] = val;
      default:                iv_m[63:0] = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_block(bit [63:0] hi, bit [63:0] lo, bit first);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {lo, hi};
    s_axis_tuser <= first;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predict_block(hi, lo, first);
    blocks_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic bit [63:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  always @(negedge clk_i)
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

  always begin
    @(stall_ev);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    block_t exp_b;
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        exp_b = expected_blocks.pop_front();
        if (m_axis_tdata[63:0] !== exp_b.hi) begin
          $display("%0t: result_high expected %h actual %h", $time, exp_b.hi,
                   m_axis_tdata[63:0]);
          error_count++;
        end
        if (m_axis_tdata[127:64] !== exp_b.lo) begin
          $display("%0t: result_low expected %h actual %h", $time, exp_b.lo,
                   m_axis_tdata[127:64]);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    cfg_write(abcm_pkg::REG_KEY_SIZE, 64'(abcm_pkg::KS_128));
    cfg_write(abcm_pkg::REG_KEY0, 64'h0001020304050607);
    cfg_write(abcm_pkg::REG_KEY1, 64'h08090a0b0c0d0e0f);
    cfg_write(abcm_pkg::REG_IV_HIGH, 64'hffffffffffffffff);
    cfg_write(abcm_pkg::REG_IV_LOW, 64'h0);
    for (int m = 0; m < 8; m++) begin
      cfg_write(abcm_pkg::REG_MODE, 64'(m));
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      send_block('1, '0, 1'b0);
      drain();
    end
    for (int ks = 1; ks < 4; ks++) begin
      cfg_write(abcm_pkg::REG_KEY_SIZE, 64'(ks));
      cfg_write(abcm_pkg::REG_KEY2, ks[0] ? '1 : '0);
      cfg_write(abcm_pkg::REG_KEY3, '1);
      cfg_write(abcm_pkg::REG_MODE, 64'(ks + 2));
      send_block('0, '0, 1'b1);
      send_block('1, '1, 1'b0);
      drain();
    end
  endtask

  task automatic test_random(int unsigned count, int unsigned tx_pct, int unsigned rx_pct);
    int unsigned goal = blocks_sent + count;
    int unsigned len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (blocks_sent < goal) begin
      drain();
      if ($urandom_range(2) == 0)
        cfg_write(abcm_pkg::REG_KEY_SIZE, 64'($urandom_range(3)));
      if ($urandom_range(1) == 0) cfg_write(abcm_pkg::REG_MODE, 64'($urandom_range(7)));
      for (int k = 0; k < 4; k++)
        if ($urandom_range(3) == 0)
          cfg_write(abcm_pkg::reg_e'(int'(abcm_pkg::REG_KEY0) + k), rand_word());
      if ($urandom_range(1) == 0) cfg_write(abcm_pkg::REG_IV_HIGH, rand_word());
      if ($urandom_range(1) == 0) cfg_write(abcm_pkg::REG_IV_LOW, rand_word());
      len = $urandom_range(12, 1);
      for (int j = 0; j < len; j++)
        send_block(rand_word(), rand_word(),
                   j == 0 ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
    end
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    cfg_write(abcm_pkg::REG_KEY_SIZE, 64'(abcm_pkg::KS_256));
    cfg_write(abcm_pkg::REG_MODE, 64'd3);
    -> stall_ev;
    for (int j = 0; j < 24; j++) send_block(rand_word(), rand_word(), j == 0);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);
    test_directed();
    test_random(430, 10, 50);
    test_random(430, 50, 10);
    test_backpressure();
    test_random(430, 0, 0);
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_blocks.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
